/* hdl/vau_pkg.sv */
// ----------------------------------------------------------------------------
// Vertex attribute unpack package
// Shared types, codes and the format decode table.
// ----------------------------------------------------------------------------
package vau_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNSUP = 2'd1;
  localparam logic [1:0] ST_INVAL = 2'd2;

  localparam logic [31:0] FP_ONE     = 32'h3f80_0000;
  localparam logic [31:0] FP_NEG_ONE = 32'hbf80_0000;

  typedef enum logic [3:0] {
    K_NONE, K_UN, K_UI, K_SN, K_SI, K_HF, K_FL, K_P44,
    K_P10UN, K_P10UI, K_P10SN, K_P10SI, K_UNSUP
  } kind_e;

  typedef enum logic [1:0] {OP_RAW, OP_UINT, OP_NORM, OP_HALF} op_e;

  typedef enum logic [2:0] {NK4, NK7, NK8, NK9, NK10, NK15, NK16} nk_e;

  typedef enum logic [2:0] {C_ZERO, C_UN, C_UI, C_SN, C_SI, C_HF, C_FL} cls_e;

  typedef enum logic [1:0] {FW8, FW10, FW16, FW32} fw_e;

  typedef struct packed {
    kind_e      kind;
    logic [2:0] size;
    logic [2:0] count;
  } desc_t;

  typedef struct packed {
    op_e         op;
    logic        sign;
    nk_e         nk;
    logic [31:0] mag;
  } lane_t;

  typedef struct packed {
    lane_t [3:0] lane;
    logic [1:0]  status;
  } cmd_t;

  typedef struct packed {
    logic [5:0]  format;
    logic [63:0] data_low;
    logic [63:0] data_high;
  } in_item_t;

  typedef struct packed {
    logic [31:0] comp_x;
    logic [31:0] comp_y;
    logic [31:0] comp_z;
    logic [31:0] comp_w;
    logic [1:0]  status;
  } out_item_t;

  function automatic desc_t fmt_decode(logic [5:0] f);
    desc_t d;
    d = '{kind: K_NONE, size: 3'd0, count: 3'd0};
    unique case (f)
      6'd1:  d = '{K_UN, 3'd1, 3'd1};
      6'd2:  d = '{K_UI, 3'd1, 3'd1};
      6'd3:  d = '{K_SN, 3'd1, 3'd1};
      6'd4:  d = '{K_SI, 3'd1, 3'd1};
      6'd5:  d = '{K_UI, 3'd1, 3'd1};
      6'd6:  d = '{K_SI, 3'd1, 3'd1};
      6'd7:  d = '{K_P44, 3'd1, 3'd2};
      6'd8:  d = '{K_UN, 3'd2, 3'd1};
      6'd9:  d = '{K_UI, 3'd2, 3'd1};
      6'd10: d = '{K_SN, 3'd2, 3'd1};
      6'd11: d = '{K_SI, 3'd2, 3'd1};
      6'd12: d = '{K_HF, 3'd2, 3'd1};
      6'd13: d = '{K_UI, 3'd2, 3'd1};
      6'd14: d = '{K_SI, 3'd2, 3'd1};
      6'd15: d = '{K_UN, 3'd1, 3'd2};
      6'd16: d = '{K_UI, 3'd1, 3'd2};
      6'd17: d = '{K_SN, 3'd1, 3'd2};
      6'd18: d = '{K_SI, 3'd1, 3'd2};
      6'd19: d = '{K_UI, 3'd1, 3'd2};
      6'd20: d = '{K_SI, 3'd1, 3'd2};
      6'd21: d = '{K_UN, 3'd2, 3'd2};
      6'd22: d = '{K_UI, 3'd2, 3'd2};
      6'd23: d = '{K_SN, 3'd2, 3'd2};
      6'd24: d = '{K_SI, 3'd2, 3'd2};
      6'd25: d = '{K_HF, 3'd2, 3'd2};
      6'd26: d = '{K_UI, 3'd2, 3'd2};
      6'd27: d = '{K_SI, 3'd2, 3'd2};
      6'd28: d = '{K_UNSUP, 3'd0, 3'd0};
      6'd29: d = '{K_UN, 3'd1, 3'd4};
      6'd30: d = '{K_UI, 3'd1, 3'd4};
      6'd31: d = '{K_SN, 3'd1, 3'd4};
      6'd32: d = '{K_SI, 3'd1, 3'd4};
      6'd33: d = '{K_UI, 3'd1, 3'd4};
      6'd34: d = '{K_SI, 3'd1, 3'd4};
      6'd35: d = '{K_P10UN, 3'd4, 3'd4};
      6'd36: d = '{K_P10UI, 3'd4, 3'd4};
      6'd37: d = '{K_P10SN, 3'd4, 3'd4};
      6'd38: d = '{K_P10SI, 3'd4, 3'd4};
      6'd39: d = '{K_UI, 3'd4, 3'd1};
      6'd40: d = '{K_SI, 3'd4, 3'd1};
      6'd41: d = '{K_FL, 3'd4, 3'd1};
      6'd42: d = '{K_UN, 3'd2, 3'd4};
      6'd43: d = '{K_SN, 3'd2, 3'd4};
      6'd44: d = '{K_UI, 3'd2, 3'd4};
      6'd45: d = '{K_SI, 3'd2, 3'd4};
      6'd46: d = '{K_HF, 3'd2, 3'd4};
      6'd47: d = '{K_UI, 3'd2, 3'd4};
      6'd48: d = '{K_SI, 3'd2, 3'd4};
      6'd49: d = '{K_UI, 3'd4, 3'd2};
      6'd50: d = '{K_SI, 3'd4, 3'd2};
      6'd51: d = '{K_FL, 3'd4, 3'd2};
      6'd52: d = '{K_UI, 3'd4, 3'd3};
      6'd53: d = '{K_SI, 3'd4, 3'd3};
      6'd54: d = '{K_FL, 3'd4, 3'd3};
      6'd55: d = '{K_UI, 3'd4, 3'd4};
      6'd56: d = '{K_SI, 3'd4, 3'd4};
      6'd57: d = '{K_FL, 3'd4, 3'd4};
      default: d = '{K_NONE, 3'd0, 3'd0};
    endcase
    return d;
  endfunction

endpackage

/* hdl/vau_front.sv */
// ----------------------------------------------------------------------------
// Vertex attribute unpack front end
// Decodes the format, assembles words and classifies each component lane.
// ----------------------------------------------------------------------------
module vau_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  vau_pkg::in_item_t  item_i,
  output vau_pkg::cmd_t      cmd_o
);

  logic byte_order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_order_q <= 1'b0;
    end else if (cfg_we_i) begin
      byte_order_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    logic [7:0]  b [16];
    logic [31:0] w1 [4];
    logic [31:0] w2 [4];
    logic [31:0] w4 [4];
    logic [31:0] fv;
    logic [31:0] mask;
    logic [31:0] negv;
    logic        sgn;
    logic        low_zero;
    vau_pkg::desc_t d;
    vau_pkg::cls_e  cls;
    vau_pkg::fw_e   fw;

    d = vau_pkg::fmt_decode(item_i.format);
    for (int k = 0; k < 8; k++) begin
      b[k]     = item_i.data_low[8*k +: 8];
      b[k + 8] = item_i.data_high[8*k +: 8];
    end
    for (int i = 0; i < 4; i++) begin
      w1[i] = {24'd0, b[i]};
      w2[i] = byte_order_q ? {16'd0, b[2*i], b[2*i+1]} : {16'd0, b[2*i+1], b[2*i]};
      w4[i] = byte_order_q ? {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]}
                           : {b[4*i+3], b[4*i+2], b[4*i+1], b[4*i]};
    end

    cmd_o.status = vau_pkg::ST_OK;
    if (d.kind == vau_pkg::K_NONE) cmd_o.status = vau_pkg::ST_INVAL;
    if (d.kind == vau_pkg::K_UNSUP) cmd_o.status = vau_pkg::ST_UNSUP;

    for (int i = 0; i < 4; i++) begin
      cls = vau_pkg::C_ZERO;
      fw  = vau_pkg::FW32;
      fv  = '0;
      case (d.kind)
        vau_pkg::K_P10UN, vau_pkg::K_P10UI, vau_pkg::K_P10SN, vau_pkg::K_P10SI: begin
          if (i == 3) begin
            cls = vau_pkg::C_UI;
            fv  = {30'd0, w4[0][31:30]};
          end else begin
            fw = vau_pkg::FW10;
            fv = {22'd0, w4[0][10*i +: 10]};
            case (d.kind)
              vau_pkg::K_P10UN: cls = vau_pkg::C_UN;
              vau_pkg::K_P10UI: cls = vau_pkg::C_UI;
              vau_pkg::K_P10SN: cls = vau_pkg::C_SN;
              default:          cls = vau_pkg::C_SI;
            endcase
          end
        end
        vau_pkg::K_UN, vau_pkg::K_UI, vau_pkg::K_SN, vau_pkg::K_SI,
        vau_pkg::K_HF, vau_pkg::K_FL: begin
          if (3'(i) < d.count) begin
            case (d.size)
              3'd1: begin fv = w1[i]; fw = vau_pkg::FW8; end
              3'd2: begin fv = w2[i]; fw = vau_pkg::FW16; end
              default: begin fv = w4[i]; fw = vau_pkg::FW32; end
            endcase
            case (d.kind)
              vau_pkg::K_UN: cls = vau_pkg::C_UN;
              vau_pkg::K_UI: cls = vau_pkg::C_UI;
              vau_pkg::K_SN: cls = vau_pkg::C_SN;
              vau_pkg::K_SI: cls = vau_pkg::C_SI;
              vau_pkg::K_HF: cls = vau_pkg::C_HF;
              default:       cls = vau_pkg::C_FL;
            endcase
          end
        end
        default: cls = vau_pkg::C_ZERO;
      endcase

      case (fw)
        vau_pkg::FW8:  begin mask = 32'h0000_00ff; sgn = fv[7];  end
        vau_pkg::FW10: begin mask = 32'h0000_03ff; sgn = fv[9];  end
        vau_pkg::FW16: begin mask = 32'h0000_ffff; sgn = fv[15]; end
        default:       begin mask = 32'hffff_ffff; sgn = fv[31]; end
      endcase
      negv     = (~fv + 32'd1) & mask;
      low_zero = ((fv & (mask >> 1)) == 32'd0);

      cmd_o.lane[i] = '{op: vau_pkg::OP_RAW, sign: 1'b0, nk: vau_pkg::NK8, mag: 32'd0};
      case (cls)
        vau_pkg::C_UN: begin
          cmd_o.lane[i].op  = vau_pkg::OP_NORM;
          cmd_o.lane[i].mag = fv;
          case (fw)
            vau_pkg::FW8:  cmd_o.lane[i].nk = vau_pkg::NK8;
            vau_pkg::FW10: cmd_o.lane[i].nk = vau_pkg::NK10;
            default:       cmd_o.lane[i].nk = vau_pkg::NK16;
          endcase
        end
        vau_pkg::C_SN: begin
          if (sgn && low_zero) begin
            cmd_o.lane[i].mag = vau_pkg::FP_NEG_ONE;
          end else begin
            cmd_o.lane[i].op   = vau_pkg::OP_NORM;
            cmd_o.lane[i].sign = sgn;
            cmd_o.lane[i].mag  = sgn ? negv : fv;
            case (fw)
              vau_pkg::FW8:  cmd_o.lane[i].nk = vau_pkg::NK7;
              vau_pkg::FW10: cmd_o.lane[i].nk = vau_pkg::NK9;
              default:       cmd_o.lane[i].nk = vau_pkg::NK15;
            endcase
          end
        end
        vau_pkg::C_UI: begin
          cmd_o.lane[i].op  = vau_pkg::OP_UINT;
          cmd_o.lane[i].mag = fv;
        end
        vau_pkg::C_SI: begin
          cmd_o.lane[i].op   = vau_pkg::OP_UINT;
          cmd_o.lane[i].sign = sgn;
          cmd_o.lane[i].mag  = sgn ? negv : fv;
        end
        vau_pkg::C_HF: begin
          cmd_o.lane[i].op  = vau_pkg::OP_HALF;
          cmd_o.lane[i].mag = fv;
        end
        vau_pkg::C_FL: cmd_o.lane[i].mag = fv;
        default: cmd_o.lane[i].mag = 32'd0;
      endcase
    end

    if (d.kind == vau_pkg::K_P44) begin
      cmd_o.lane[0] = '{op: vau_pkg::OP_NORM, sign: 1'b0, nk: vau_pkg::NK4,
                        mag: {28'd0, b[0][3:0]}};
      cmd_o.lane[1] = '{op: vau_pkg::OP_NORM, sign: 1'b0, nk: vau_pkg::NK4,
                        mag: {28'd0, b[0][7:4]}};
    end
  end

endmodule

/* hdl/vau_queue.sv */
// ----------------------------------------------------------------------------
// Vertex attribute unpack command queue
// Short queue that decouples the front end from the conversion back end.
// ----------------------------------------------------------------------------
module vau_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vau_pkg::cmd_t  wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output vau_pkg::cmd_t  rdata_o
);

  vau_pkg::cmd_t              mem_q [vau_pkg::QDepth];
  logic [vau_pkg::QPtrW-1:0]  wr_q, rd_q;
  logic [vau_pkg::QPtrW:0]    cnt_q;

  assign full_o  = (cnt_q == (vau_pkg::QPtrW+1)'(vau_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

/* hdl/vau_back.sv */
// ----------------------------------------------------------------------------
// Vertex attribute unpack back end
// Leading-zero stage, then normalize/round stage into the result register.
// ----------------------------------------------------------------------------
module vau_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  vau_pkg::cmd_t       cmd_i,
  output logic                cmd_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output vau_pkg::out_item_t  out_item_o
);

  function automatic logic [5:0] lzc32(logic [31:0] v);
    logic [5:0] n;
    logic       hit;
    n   = 6'd32;
    hit = 1'b0;
    for (int k = 31; k >= 0; k--) begin
      if (v[k] && !hit) begin
        n   = 6'(31 - k);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [31:0] finish(vau_pkg::lane_t l, logic [5:0] lz);
    logic [31:0] r;
    logic [31:0] sh;
    logic [95:0] w96;
    logic [63:0] t;
    logic [31:0] kmask;
    logic [30:0] base;
    logic        up;
    logic [9:0]  mn;
    r = l.mag;
    unique case (l.op)
      vau_pkg::OP_UINT: begin
        sh   = l.mag << lz[4:0];
        up   = sh[7] & ((|sh[6:0]) | sh[8]);
        base = {8'd158 - {2'd0, lz}, sh[30:8]} + 31'(up);
        r    = (l.mag == 32'd0) ? 32'd0 : {l.sign, base};
      end
      vau_pkg::OP_NORM: begin
        case (l.nk)
          vau_pkg::NK4:  begin kmask = 32'h000f; w96 = {24{l.mag[3:0]}}; end
          vau_pkg::NK7:  begin kmask = 32'h007f; w96 = {{13{l.mag[6:0]}}, 5'd0}; end
          vau_pkg::NK8:  begin kmask = 32'h00ff; w96 = {12{l.mag[7:0]}}; end
          vau_pkg::NK9:  begin kmask = 32'h01ff; w96 = {{10{l.mag[8:0]}}, 6'd0}; end
          vau_pkg::NK10: begin kmask = 32'h03ff; w96 = {{9{l.mag[9:0]}}, 6'd0}; end
          vau_pkg::NK15: begin kmask = 32'h7fff; w96 = {{6{l.mag[14:0]}}, 6'd0}; end
          default:       begin kmask = 32'hffff; w96 = {6{l.mag[15:0]}}; end
        endcase
        t    = w96[95:32] << lz[4:0];
        base = {8'd126 - {2'd0, lz}, t[62:40]} + 31'(t[39]);
        if (l.mag == 32'd0) r = 32'd0;
        else if (l.mag == kmask) r = {l.sign, vau_pkg::FP_ONE[30:0]};
        else r = {l.sign, base};
      end
      vau_pkg::OP_HALF: begin
        mn = 10'({1'b0, l.mag[9:0]} << (lz[3:0] + 4'd1));
        if (l.mag[14:10] == 5'd0) begin
          if (l.mag[9:0] == 10'd0) r = {l.mag[15], 31'd0};
          else r = {l.mag[15], 8'd112 - {2'd0, lz}, mn, 13'd0};
        end else if (l.mag[14:10] == 5'h1f) begin
          r = {l.mag[15], 8'hff, l.mag[9:0], 13'd0};
        end else begin
          r = {l.mag[15], {3'd0, l.mag[14:10]} + 8'd112, l.mag[9:0], 13'd0};
        end
      end
      default: r = l.mag;
    endcase
    return r;
  endfunction

  vau_pkg::cmd_t       s1_q;
  logic [3:0][5:0]     lz_q;
  logic [3:0][5:0]     lz_d;
  logic                s1_v_q, o_v_q;
  logic                s1_load, o_load;
  vau_pkg::out_item_t  out_q, out_d;

  assign o_load    = s1_v_q && (!o_v_q || pop_i);
  assign s1_load   = !s1_v_q || o_load;
  assign cmd_pop_o = cmd_valid_i && s1_load;
  assign empty_o   = !o_v_q;
  assign out_item_o = out_q;

  always_comb begin
    logic [31:0] al;
    for (int i = 0; i < 4; i++) begin
      al = 32'd0;
      case (cmd_i.lane[i].op)
        vau_pkg::OP_UINT: al = cmd_i.lane[i].mag;
        vau_pkg::OP_HALF: al = {cmd_i.lane[i].mag[9:0], 22'd0};
        vau_pkg::OP_NORM: begin
          case (cmd_i.lane[i].nk)
            vau_pkg::NK4:  al = {cmd_i.lane[i].mag[3:0], 28'd0};
            vau_pkg::NK7:  al = {cmd_i.lane[i].mag[6:0], 25'd0};
            vau_pkg::NK8:  al = {cmd_i.lane[i].mag[7:0], 24'd0};
            vau_pkg::NK9:  al = {cmd_i.lane[i].mag[8:0], 23'd0};
            vau_pkg::NK10: al = {cmd_i.lane[i].mag[9:0], 22'd0};
            vau_pkg::NK15: al = {cmd_i.lane[i].mag[14:0], 17'd0};
            default:       al = {cmd_i.lane[i].mag[15:0], 16'd0};
          endcase
        end
        default: al = 32'd0;
      endcase
      lz_d[i] = lzc32(al);
    end
  end

  always_comb begin
    out_d.comp_x = finish(s1_q.lane[0], lz_q[0]);
    out_d.comp_y = finish(s1_q.lane[1], lz_q[1]);
    out_d.comp_z = finish(s1_q.lane[2], lz_q[2]);
    out_d.comp_w = finish(s1_q.lane[3], lz_q[3]);
    out_d.status = s1_q.status;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      s1_q <= cmd_i;
      lz_q <= lz_d;
    end
    if (o_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (s1_load) s1_v_q <= cmd_valid_i;
      if (o_load) o_v_q <= 1'b1;
      else if (pop_i) o_v_q <= 1'b0;
    end
  end

endmodule

/* hdl/vertex_attribute_unpack.sv */
// ----------------------------------------------------------------------------
// Vertex attribute unpack
// Converts one raw vertex attribute element into four IEEE single components.
// ----------------------------------------------------------------------------
// Takes one attribute element per cycle when full is low and gives one result
// per cycle while pop keeps up. A result passes in order through the four-entry
// command queue behind the decoder, the leading-zero stage of the conversion
// lanes and the result register, where it sits until popped. byte_order is
// written through cfg_we_i and cfg_wdata_i and applies to items pushed after
// the write.
module vertex_attribute_unpack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  vau_pkg::in_item_t   in_item_i,
  output logic                empty,
  input  logic                pop,
  output vau_pkg::out_item_t  out_item_o
);

  vau_pkg::cmd_t  cmd_in, cmd_out;
  logic           q_empty, q_pop, q_push;

  assign q_push = push && !full;

  vau_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (in_item_i),
    .cmd_o       (cmd_in)
  );

  vau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (cmd_out)
  );

  vau_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_item_o  (out_item_o)
  );

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("queue popped while empty");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |=> !q_empty) else $error("pushed transaction missing from queue");

  a_bad_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.status != vau_pkg::ST_OK) |->
      (out_item_o.comp_x == 32'd0 && out_item_o.comp_y == 32'd0 &&
       out_item_o.comp_z == 32'd0 && out_item_o.comp_w == 32'd0))
    else $error("nonzero components on failed format");
`endif

endmodule

/* test/vertex_attribute_unpack_tb.sv */
// ----------------------------------------------------------------------------
// Vertex attribute unpack testbench
// Pushes raw attribute elements of every format under both byte orders,
// predicts the four IEEE single components and status of each one, and
// compares every popped result field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vertex_attribute_unpack_tb;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_wdata_i = 1'b0;
  logic               push = 1'b0;
  logic               full;
  vau_pkg::in_item_t  in_item_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  vau_pkg::out_item_t out_item_o;

  vau_pkg::out_item_t expected_q[$];
  logic      big_endian = 1'b0;
  logic      steady = 1'b0;
  int        errors = 0;

  vertex_attribute_unpack dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .push, .full,
    .in_item_i, .empty, .pop, .out_item_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // round a double to single precision bits, nearest even
  function automatic logic [31:0] to_single(real r);
    logic [63:0] db;
    logic [52:0] m;
    logic [24:0] keep;
    logic [28:0] rem;
    int          e;
    db = $realtobits(r);
    if (db[62:0] == '0) return {db[63], 31'd0};
    m = {1'b1, db[51:0]};
    keep = {1'b0, m[52:29]};
    rem = m[28:0];
    e = int'(db[62:52]) - 1023 + 127;
    if (rem > 29'h1000_0000 || (rem == 29'h1000_0000 && keep[0])) keep++;
    if (keep[24]) begin
      keep = keep >> 1;
      e++;
    end
    return {db[63], e[7:0], keep[22:0]};
  endfunction

  function automatic logic [31:0] widen_half(logic [15:0] h);
    logic [9:0] m;
    int         e;
    m = h[9:0];
    if (h[14:10] == 5'd0) begin
      if (m == 0) return {h[15], 31'd0};
      e = 112;
      while (!m[9]) begin
        m = m << 1;
        e--;
      end
      m = m << 1;
      return {h[15], e[7:0], m, 13'd0};
    end
    if (h[14:10] == 5'h1f) return {h[15], 8'hff, m, 13'd0};
    return {h[15], 8'(h[14:10] + 112), m, 13'd0};
  endfunction

  function automatic real norm_signed(longint v, real div);
    real r;
    r = real'(v) / div;
    return (r < -1.0) ? -1.0 : r;
  endfunction

  function automatic vau_pkg::out_item_t unpack_attribute(vau_pkg::in_item_t it);
    vau_pkg::out_item_t o;
    logic [127:0]  raw;
    logic [31:0]   c[4];
    logic [31:0]   w;
    logic [9:0]    f;
    vau_pkg::kind_e kd;
    int            sz, cnt, bits;
    longint        sv;
    raw = {it.data_high, it.data_low};
    c = '{default: 32'd0};
    o = '0;
    sz = 0;
    cnt = 0;
    kd = vau_pkg::K_NONE;
    case (it.format)
      1, 15, 29:               kd = vau_pkg::K_UN;
      2, 5, 16, 19, 30, 33:    kd = vau_pkg::K_UI;
      3, 17, 31:               kd = vau_pkg::K_SN;
      4, 6, 18, 20, 32, 34:    kd = vau_pkg::K_SI;
      8, 21, 42:               kd = vau_pkg::K_UN;
      9, 13, 22, 26, 44, 47:   kd = vau_pkg::K_UI;
      10, 23, 43:              kd = vau_pkg::K_SN;
      11, 14, 24, 27, 45, 48:  kd = vau_pkg::K_SI;
      12, 25, 46:              kd = vau_pkg::K_HF;
      7:                       kd = vau_pkg::K_P44;
      28:                      kd = vau_pkg::K_UNSUP;
      35:                      kd = vau_pkg::K_P10UN;
      36:                      kd = vau_pkg::K_P10UI;
      37:                      kd = vau_pkg::K_P10SN;
      38:                      kd = vau_pkg::K_P10SI;
      39, 49, 52, 55:          kd = vau_pkg::K_UI;
      40, 50, 53, 56:          kd = vau_pkg::K_SI;
      41, 51, 54, 57:          kd = vau_pkg::K_FL;
      default:                 kd = vau_pkg::K_NONE;
    endcase
    if (it.format <= 6) begin sz = 1; cnt = 1; end
    else if (it.format <= 14) begin sz = 2; cnt = 1; end
    else if (it.format <= 20) begin sz = 1; cnt = 2; end
    else if (it.format <= 27) begin sz = 2; cnt = 2; end
    else if (it.format <= 34) begin sz = 1; cnt = 4; end
    else if (it.format <= 41) begin sz = 4; cnt = 1; end
    else if (it.format <= 48) begin sz = 2; cnt = 4; end
    else begin sz = 4; cnt = (it.format - 43) / 3; end
    bits = 8 * sz;
    case (kd)
      vau_pkg::K_NONE:  o.status = vau_pkg::ST_INVAL;
      vau_pkg::K_UNSUP: o.status = vau_pkg::ST_UNSUP;
      vau_pkg::K_P44: begin
        c[0] = to_single(real'(raw[3:0]) / 15.0);
        c[1] = to_single(real'(raw[7:4]) / 15.0);
      end
      vau_pkg::K_P10UN, vau_pkg::K_P10UI, vau_pkg::K_P10SN, vau_pkg::K_P10SI: begin
        w = big_endian ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw[31:0];
        for (int i = 0; i < 3; i++) begin
          f = w[10*i +: 10];
          sv = f[9] ? longint'(f) - 1024 : longint'(f);
          case (kd)
            vau_pkg::K_P10UN: c[i] = to_single(real'(f) / 1023.0);
            vau_pkg::K_P10UI: c[i] = to_single(real'(f));
            vau_pkg::K_P10SN: c[i] = to_single(norm_signed(sv, 511.0));
            default:          c[i] = to_single(real'(sv));
          endcase
        end
        c[3] = to_single(real'(w[31:30]));
      end
      default: begin
        for (int i = 0; i < cnt; i++) begin
          w = '0;
          for (int k = 0; k < sz; k++) begin
            if (big_endian) w = (w << 8) | 32'(raw[8*(i*sz + k) +: 8]);
            else w[8*k +: 8] = raw[8*(i*sz + k) +: 8];
          end
          sv = w[bits-1] ? longint'(w) - (longint'(1) << bits) : longint'(w);
          case (kd)
            vau_pkg::K_UN: c[i] = to_single(real'(w) / ((sz == 1) ? 255.0 : 65535.0));
            vau_pkg::K_UI: c[i] = to_single(real'(w));
            vau_pkg::K_SN: c[i] = to_single(norm_signed(sv, (sz == 1) ? 127.0 : 32767.0));
            vau_pkg::K_SI: c[i] = to_single(real'(sv));
            vau_pkg::K_HF: c[i] = widen_half(w[15:0]);
            default: c[i] = w;
          endcase
        end
      end
    endcase
    o.comp_x = c[0];
    o.comp_y = c[1];
    o.comp_z = c[2];
    o.comp_w = c[3];
    return o;
  endfunction

  task automatic send_element(logic [5:0] fmt, logic [63:0] lo, logic [63:0] hi);
    vau_pkg::in_item_t it;
    it = '{format: fmt, data_low: lo, data_high: hi};
    if (!steady && $urandom_range(99) < 33) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    expected_q.push_back(unpack_attribute(it));
    @(negedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic set_byte_order(logic be);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= be;
    big_endian = be;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_element(6'd0, '1, '1);
    send_element(6'd28, rand64(), rand64());
    send_element(6'd63, '1, '1);
    send_element(6'd58, '0, '0);
    send_element(6'd7, 64'hff, '0);
    send_element(6'd7, 64'h0f, '0);
    send_element(6'd31, 64'h7f80_7f80, '0);
    send_element(6'd1, 64'hff, '0);
    send_element(6'd43, 64'h8000_7fff_8001_0000, '0);
    send_element(6'd46, 64'h0001_fe01_7c00_fc00, '0);
    send_element(6'd25, 64'h83ff_0400, '0);
    send_element(6'd41, 64'h7fc0_1234, '0);
    send_element(6'd57, '1, 64'hff80_0000_7f80_0000);
    send_element(6'd35, 64'hffff_ffff, '0);
    send_element(6'd36, 64'h3fff_ffff, '0);
    send_element(6'd37, 64'h6020_0802, '0);
    send_element(6'd38, 64'hdff7_fdff, '0);
    send_element(6'd39, 64'hffff_ffff, '0);
    send_element(6'd40, 64'h8000_0000, '0);
    send_element(6'd55, 64'hffff_ff01_ffff_ffff, 64'h0100_0001_7fff_ffc0);
    send_element(6'd14, 64'h8000, '1);
    send_element(6'd27, 64'h7fff_8000, '0);
  endtask

  task automatic test_random(int n);
    logic [5:0] fmt;
    for (int i = 0; i < n; i++) begin
      fmt = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(57, 1));
      send_element(fmt, rand64(), rand64());
    end
  endtask

  always @(posedge clk_i) begin
    vau_pkg::out_item_t exp_item;
    if (rst_ni && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transaction: %h", out_item_o);
        errors++;
      end else begin
        exp_item = expected_q.pop_front();
        if (out_item_o.comp_x !== exp_item.comp_x) begin
          $error("comp_x expected %h actual %h", exp_item.comp_x, out_item_o.comp_x);
          errors++;
        end
        if (out_item_o.comp_y !== exp_item.comp_y) begin
          $error("comp_y expected %h actual %h", exp_item.comp_y, out_item_o.comp_y);
          errors++;
        end
        if (out_item_o.comp_z !== exp_item.comp_z) begin
          $error("comp_z expected %h actual %h", exp_item.comp_z, out_item_o.comp_z);
          errors++;
        end
        if (out_item_o.comp_w !== exp_item.comp_w) begin
          $error("comp_w expected %h actual %h", exp_item.comp_w, out_item_o.comp_w);
          errors++;
        end
        if (out_item_o.status !== exp_item.status) begin
          $error("status expected %0d actual %0d", exp_item.status, out_item_o.status);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) pop <= steady || ($urandom_range(99) >= 33);

  initial begin
    #2_000_000;
    $display("vertex_attribute_unpack_tb NOT OK");
    $finish;
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(400);
    set_byte_order(1'b1);
    test_directed();
    test_random(400);
    steady = 1'b1;
    test_random(200);
    steady = 1'b0;
    set_byte_order(1'b0);
    test_random(350);
    set_byte_order(1'b1);
    test_random(350);
    drain();
    if (errors == 0) begin
      $display("vertex_attribute_unpack_tb OK");
    end else begin
      $display("vertex_attribute_unpack_tb NOT OK");
    end
    $finish;
  end
endmodule
